/* rtl/core/btbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btbp_pkg
// Shared types, constants and the bevel normal table for the metal text shader.
// ----------------------------------------------------------------------------
package btbp_pkg;

    // geometry defaults
    localparam int SCREEN_WIDTH_DEF = 360;
    localparam int TEXT_ROWS_DEF    = 64;
    localparam int TEXT_TOP         = 124;
    localparam int CENTER_Y         = 140;
    localparam int MARGIN           = 20;
    localparam int EYE_DIST2        = 340;

    // shading constants
    localparam int PAL_BASE   = 144;
    localparam int SHADES     = 64;
    localparam int DIFFUSE_W  = 1638;
    localparam int Q_ONE      = 16384;
    localparam int Q_HALF     = 8192;
    localparam int Q_FRAC     = 14;
    localparam int NORM_SHIFT = 28;

    // vector widths
    localparam int VEC_W  = 17;
    localparam int UNIT_W = 16;
    localparam int SIDE_W = 5;

    // configuration register indexes
    localparam logic [1:0] REG_LIGHT_X = 2'd0;
    localparam logic [1:0] REG_LIGHT_Y = 2'd1;
    localparam logic [1:0] REG_LIGHT_Z = 2'd2;

    typedef struct packed {
        logic signed [UNIT_W-1:0] z;
        logic signed [UNIT_W-1:0] y;
        logic signed [UNIT_W-1:0] x;
    } t_unit_vec;

    // unit normal of (left-right, up-down, 2) in Q2.14
    function automatic t_unit_vec normal_q(input logic [3:0] ink);
        logic      l;
        logic      r;
        logic      u;
        logic      d;
        logic      hx;
        logic      hy;
        t_unit_vec n;
        logic signed [UNIT_W-1:0] c;
        l  = ink[0];
        r  = ink[1];
        u  = ink[2];
        d  = ink[3];
        hx = l ^ r;
        hy = u ^ d;
        n  = '0;
        case ({hx, hy})
            2'b00: begin
                c   = '0;
                n.z = 16'sd16384;
            end
            2'b11: begin
                c   = 16'sd6689;
                n.z = 16'sd13378;
            end
            default: begin
                c   = 16'sd7327;
                n.z = 16'sd14655;
            end
        endcase
        n.x = hx ? (l ? c : -c) : '0;
        n.y = hy ? (u ? c : -c) : '0;
        return n;
    endfunction

endpackage

/* rtl/core/btbp_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btbp_norm
// Pipelined Q2.14 vector normalizer: square sum, bit-per-stage square root,
// bit-per-stage rounded division on three lanes, sideband carried alongside.
// ----------------------------------------------------------------------------
module btbp_norm #(
    parameter int IN_W   = btbp_pkg::VEC_W,
    parameter int SIDE_W = btbp_pkg::SIDE_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [2:0][IN_W-1:0]       i_vec,      // signed lanes x, y, z
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output btbp_pkg::t_unit_vec        o_vec,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int SW  = 2 * IN_W + 2;
    localparam int XW  = SW + btbp_pkg::NORM_SHIFT;
    localparam int K   = XW / 2;
    localparam int LW  = K;
    localparam int QN  = btbp_pkg::UNIT_W;
    localparam int DW  = LW + QN + 1;
    localparam int LAT = 5 + K + QN;
    localparam logic [XW:0] ONE = {{XW{1'b0}}, 1'b1};

    logic                r_valid [LAT];
    logic [SIDE_W-1:0]   r_side  [LAT];

    // magnitude and square stages
    logic [IN_W-1:0]     r_m0  [3];
    logic                r_ng0 [3];
    logic [IN_W-1:0]     r_m1  [3];
    logic                r_ng1 [3];
    logic [2*IN_W-1:0]   r_sq1 [3];

    // square root stages, index 0 holds the scaled sum
    logic [XW:0]         r_v  [K+1];
    logic [XW:0]         r_r  [K+1];
    logic [IN_W-1:0]     r_sm [K+1][3];
    logic                r_sn [K+1][3];
    logic                r_sz [K+1];
    logic [XW:0]         n_v  [K];
    logic [XW:0]         n_r  [K];

    // division stages, index 0 holds the rounded dividend
    logic [DW-1:0]       r_rem [QN+1][3];
    logic [QN-1:0]       r_q   [QN+1][3];
    logic [LW-1:0]       r_len [QN+1];
    logic                r_dn  [QN+1][3];
    logic                r_dz  [QN+1];
    logic [DW-1:0]       n_rem [QN][3];
    logic [QN-1:0]       n_q   [QN][3];

    logic [SW-1:0]       n_sum;
    btbp_pkg::t_unit_vec r_out;

    assign n_sum = SW'(r_sq1[0]) + SW'(r_sq1[1]) + SW'(r_sq1[2]);

    always_comb begin
        for (int j = 0; j < K; j++) begin
            if (r_v[j] >= r_r[j] + (ONE << (2 * (K - 1 - j)))) begin
                n_v[j] = r_v[j] - (r_r[j] + (ONE << (2 * (K - 1 - j))));
                n_r[j] = (r_r[j] >> 1) + (ONE << (2 * (K - 1 - j)));
            end else begin
                n_v[j] = r_v[j];
                n_r[j] = r_r[j] >> 1;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < QN; j++) begin
            for (int i = 0; i < 3; i++) begin
                if (r_rem[j][i] >= (DW'(r_len[j]) << (QN - 1 - j))) begin
                    n_rem[j][i] = r_rem[j][i] - (DW'(r_len[j]) << (QN - 1 - j));
                    n_q[j][i]   = r_q[j][i] | (QN'(1) << (QN - 1 - j));
                end else begin
                    n_rem[j][i] = r_rem[j][i];
                    n_q[j][i]   = r_q[j][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < LAT; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < LAT; s++) begin
                r_side[s] <= r_side[s-1];
            end

            for (int i = 0; i < 3; i++) begin
                r_ng0[i] <= i_vec[i][IN_W-1];
                r_m0[i]  <= i_vec[i][IN_W-1] ? (~i_vec[i] + IN_W'(1)) : i_vec[i];
                r_m1[i]  <= r_m0[i];
                r_ng1[i] <= r_ng0[i];
                r_sq1[i] <= (2*IN_W)'(r_m0[i]) * (2*IN_W)'(r_m0[i]);
                r_sm[0][i] <= r_m1[i];
                r_sn[0][i] <= r_ng1[i];
            end
            r_v[0]  <= {1'b0, n_sum, {btbp_pkg::NORM_SHIFT{1'b0}}};
            r_r[0]  <= '0;
            r_sz[0] <= (n_sum == '0);

            for (int j = 0; j < K; j++) begin
                r_v[j+1]  <= n_v[j];
                r_r[j+1]  <= n_r[j];
                r_sz[j+1] <= r_sz[j];
                for (int i = 0; i < 3; i++) begin
                    r_sm[j+1][i] <= r_sm[j][i];
                    r_sn[j+1][i] <= r_sn[j][i];
                end
            end

            // dividend is m << 28 plus half the length for rounding
            r_len[0] <= r_r[K][LW-1:0];
            r_dz[0]  <= r_sz[K];
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= (DW'(r_sm[K][i]) << btbp_pkg::NORM_SHIFT)
                             + DW'(r_r[K][LW-1:1]);
                r_q[0][i]   <= '0;
                r_dn[0][i]  <= r_sn[K][i];
            end

            for (int j = 0; j < QN; j++) begin
                r_len[j+1] <= r_len[j];
                r_dz[j+1]  <= r_dz[j];
                for (int i = 0; i < 3; i++) begin
                    r_rem[j+1][i] <= n_rem[j][i];
                    r_q[j+1][i]   <= n_q[j][i];
                    r_dn[j+1][i]  <= r_dn[j][i];
                end
            end

            r_out.x <= r_dz[QN] ? '0 : (r_dn[QN][0] ? -$signed(r_q[QN][0])
                                                    : $signed(r_q[QN][0]));
            r_out.y <= r_dz[QN] ? '0 : (r_dn[QN][1] ? -$signed(r_q[QN][1])
                                                    : $signed(r_q[QN][1]));
            r_out.z <= r_dz[QN] ? '0 : (r_dn[QN][2] ? -$signed(r_q[QN][2])
                                                    : $signed(r_q[QN][2]));
        end
    end

    assign o_valid = r_valid[LAT-1];
    assign o_side  = r_side[LAT-1];
    assign o_vec   = r_out;

endmodule

/* rtl/core/bevel_text_blinn_phong_shader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bevel_text_blinn_phong_shader
// Shades one text-mask pixel as polished metal: bevel normal, view and halfway
// vectors, Lambert diffuse plus an 8th-power highlight, mapped to a palette.
// ----------------------------------------------------------------------------
// channel   direction  fields (low bit first)
// s_axis    in         center, left, right, up, down ink, screen_column, text_row
// m_axis    out        write_enable, palette_index
// cfg       in         light_x, light_y, light_z by index 0..2
//
// one pixel per clock unless the output stalls; two normalizer pipelines of
// 53 stages each (32-step square root, 16-step divider) plus nine more stages.
// reset clears all valid bits and loads the light as (0, 0, 1.0).
// a stalled output holds the whole pipeline; s_axis_tready follows that stall.
// ----------------------------------------------------------------------------
module bevel_text_blinn_phong_shader #(
    parameter int SCREEN_WIDTH = btbp_pkg::SCREEN_WIDTH_DEF,
    parameter int TEXT_ROWS    = btbp_pkg::TEXT_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // center_ink, left_ink, right_ink, up_ink, down_ink, screen_column[8:0],
    // text_row[5:0], zero fill
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // write_enable, palette_index[7:0], zero fill
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    localparam int VW = btbp_pkg::VEC_W;

    logic en;

    logic signed [15:0] r_light_x;
    logic signed [15:0] r_light_y;
    logic [14:0]        r_light_z;

    logic [8:0]  col;
    logic [5:0]  row;
    logic        in_margin;

    logic                r_t0_valid;
    logic [4:0]          r_t0_side;
    logic [2:0][VW-1:0]  r_t0_vec;

    logic                v_valid;
    btbp_pkg::t_unit_vec v_vec;
    logic [4:0]          v_side;

    logic                r_t1_valid;
    logic [4:0]          r_t1_side;
    logic [2:0][VW-1:0]  r_t1_vec;

    logic                h_valid;
    btbp_pkg::t_unit_vec h_vec;
    logic [4:0]          h_side;
    btbp_pkg::t_unit_vec nrm;

    logic               r_p1_valid;
    logic               r_p1_we;
    logic signed [31:0] r_p1_nl [3];
    logic signed [31:0] r_p1_nh [3];

    logic signed [33:0] dl;
    logic signed [33:0] dh;
    logic signed [33:0] dl_r;
    logic signed [33:0] dh_r;
    logic [19:0]        n_dif;
    logic [19:0]        spec_raw;
    logic [14:0]        n_spec;

    logic        r_p2_valid;
    logic        r_p2_we;
    logic [19:0] r_p2_dif;
    logic [14:0] r_p2_s;

    logic        r_p3_valid;
    logic        r_p3_we;
    logic [30:0] r_p3_dm;
    logic [29:0] r_p3_sq;

    logic [30:0] dm_r;
    logic [29:0] sq3_r;
    logic [14:0] s1;

    logic        r_p4_valid;
    logic        r_p4_we;
    logic [16:0] r_p4_dt;
    logic [29:0] r_p4_sq;

    logic [29:0] sq4_r;
    logic [14:0] s2;

    logic        r_p5_valid;
    logic        r_p5_we;
    logic [16:0] r_p5_dt;
    logic [29:0] r_p5_sq;

    logic [29:0] sq5_r;
    logic [14:0] s3;
    logic [16:0] s3x5;
    logic [17:0] n_int;

    logic        r_p6_valid;
    logic        r_p6_we;
    logic [14:0] r_p6_int;

    logic [20:0] shade_p;
    logic [5:0]  shade;

    logic        r_out_valid;
    logic        r_out_we;
    logic [7:0]  r_out_pal;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // light registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= 15'(btbp_pkg::Q_ONE);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                btbp_pkg::REG_LIGHT_X: r_light_x <= i_cfg_wdata;
                btbp_pkg::REG_LIGHT_Y: r_light_y <= i_cfg_wdata;
                btbp_pkg::REG_LIGHT_Z: r_light_z <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // input decode and view vector
    assign col = s_axis_tdata[13:5];
    assign row = s_axis_tdata[19:14];
    assign in_margin = s_axis_tdata[0]
                    && ({2'b0, col} >= 11'(btbp_pkg::MARGIN))
                    && ({2'b0, col} < 11'(SCREEN_WIDTH - btbp_pkg::MARGIN))
                    && ({2'b0, row} < 8'(TEXT_ROWS));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t0_side   <= {s_axis_tdata[4:1], in_margin};
            r_t0_vec[0] <= VW'(SCREEN_WIDTH) - {7'b0, col, 1'b0};
            r_t0_vec[1] <= VW'(2 * (btbp_pkg::CENTER_Y - btbp_pkg::TEXT_TOP))
                         - {10'b0, row, 1'b0};
            r_t0_vec[2] <= VW'(btbp_pkg::EYE_DIST2);
        end
    end

    btbp_norm #(.IN_W(VW), .SIDE_W(5)) u_view_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_t0_valid),
        .i_vec   (r_t0_vec),
        .i_side  (r_t0_side),
        .o_valid (v_valid),
        .o_vec   (v_vec),
        .o_side  (v_side)
    );

    // halfway vector before normalizing
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_side   <= v_side;
            r_t1_vec[0] <= VW'(r_light_x) + VW'(v_vec.x);
            r_t1_vec[1] <= VW'(r_light_y) + VW'(v_vec.y);
            r_t1_vec[2] <= VW'({1'b0, r_light_z}) + VW'(v_vec.z);
        end
    end

    btbp_norm #(.IN_W(VW), .SIDE_W(5)) u_half_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_t1_valid),
        .i_vec   (r_t1_vec),
        .i_side  (r_t1_side),
        .o_valid (h_valid),
        .o_vec   (h_vec),
        .o_side  (h_side)
    );

    assign nrm = btbp_pkg::normal_q(h_side[4:1]);

    // dot products and rounding
    assign dl = 34'(r_p1_nl[0]) + 34'(r_p1_nl[1]) + 34'(r_p1_nl[2]);
    assign dh = 34'(r_p1_nh[0]) + 34'(r_p1_nh[1]) + 34'(r_p1_nh[2]);
    assign dl_r = dl + 34'sd8192;
    assign dh_r = dh + 34'sd8192;
    assign n_dif    = (dl <= 0) ? '0 : dl_r[33:14];
    assign spec_raw = (dh <= 0) ? '0 : dh_r[33:14];
    assign n_spec   = (spec_raw > 20'(btbp_pkg::Q_ONE)) ? 15'(btbp_pkg::Q_ONE)
                                                        : spec_raw[14:0];

    // three squarings of the highlight
    assign dm_r  = r_p3_dm + 31'(btbp_pkg::Q_HALF);
    assign sq3_r = r_p3_sq + 30'(btbp_pkg::Q_HALF);
    assign s1    = sq3_r[28:14];
    assign sq4_r = r_p4_sq + 30'(btbp_pkg::Q_HALF);
    assign s2    = sq4_r[28:14];
    assign sq5_r = r_p5_sq + 30'(btbp_pkg::Q_HALF);
    assign s3    = sq5_r[28:14];
    assign s3x5  = 17'(s3) * 17'd5;
    assign n_int = 18'(r_p5_dt) + 18'(s3x5[16:2]);

    assign shade_p = 21'(r_p6_int) * 21'(btbp_pkg::SHADES - 1);
    assign shade   = shade_p[19:14];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_valid  <= 1'b0;
            r_t1_valid  <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_p4_valid  <= 1'b0;
            r_p5_valid  <= 1'b0;
            r_p6_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_t0_valid  <= s_axis_tvalid;
            r_t1_valid  <= v_valid;
            r_p1_valid  <= h_valid;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_p4_valid  <= r_p3_valid;
            r_p5_valid  <= r_p4_valid;
            r_p6_valid  <= r_p5_valid;
            r_out_valid <= r_p6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_we    <= h_side[0];
            r_p1_nl[0] <= nrm.x * r_light_x;
            r_p1_nl[1] <= nrm.y * r_light_y;
            r_p1_nl[2] <= nrm.z * $signed({1'b0, r_light_z});
            r_p1_nh[0] <= nrm.x * h_vec.x;
            r_p1_nh[1] <= nrm.y * h_vec.y;
            r_p1_nh[2] <= nrm.z * h_vec.z;

            r_p2_we  <= r_p1_we;
            r_p2_dif <= n_dif;
            r_p2_s   <= n_spec;

            r_p3_we <= r_p2_we;
            r_p3_dm <= 31'(r_p2_dif) * 31'(btbp_pkg::DIFFUSE_W);
            r_p3_sq <= 30'(r_p2_s) * 30'(r_p2_s);

            r_p4_we <= r_p3_we;
            r_p4_dt <= dm_r[30:14];
            r_p4_sq <= 30'(s1) * 30'(s1);

            r_p5_we <= r_p4_we;
            r_p5_dt <= r_p4_dt;
            r_p5_sq <= 30'(s2) * 30'(s2);

            r_p6_we  <= r_p5_we;
            r_p6_int <= (n_int > 18'(btbp_pkg::Q_ONE)) ? 15'(btbp_pkg::Q_ONE)
                                                       : n_int[14:0];

            r_out_we  <= r_p6_we;
            r_out_pal <= r_p6_we ? 8'(btbp_pkg::PAL_BASE) + {2'b0, shade} : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_pal, r_out_we};

endmodule
